FILE: hdl/pph_pkg.sv
// ----------------------------------------------------------------------------
// pph_pkg: shared types and constants
// Word formats, configuration register indexes, store request bundle and the
// saturating count helper of the projection histogram.
// ----------------------------------------------------------------------------
package pph_pkg;

  // Raster position and count widths
  localparam int unsigned PosW   = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned Span   = 1024;
  localparam int unsigned CfgW   = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0] CountCap = 11'd1024;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_COUNT_NONZERO = 2'd2
  } cfg_idx_e;

  // Input word actions
  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  // Result kinds
  typedef enum logic {
    KIND_ROW    = 1'b0,
    KIND_COLUMN = 1'b1
  } kind_e;

  typedef struct packed {
    logic            action;
    logic [7:0]      blue;
    logic [7:0]      green;
    logic [7:0]      red;
    logic [PosW-1:0] column_select;
  } in_word_t;

  typedef struct packed {
    logic            result_kind;
    logic [PosW-1:0] position;
    logic [CntW-1:0] tally;
    logic            frame_done;
  } out_word_t;

  // Read and write requests to the column count store
  typedef struct packed {
    logic            rd_en;
    logic [PosW-1:0] rd_addr;
    logic            wr_en;
    logic [PosW-1:0] wr_addr;
    logic [CntW-1:0] wr_data;
  } store_req_t;

  // Add one, saturating at the count cap
  function automatic logic [CntW-1:0] bump(logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    if (v >= CountCap) begin
      r = CountCap;
    end else begin
      r = v + 11'd1;
    end
    return r;
  endfunction

endpackage

FILE: hdl/pixel_projection_histogram_top.sv
// ----------------------------------------------------------------------------
// pixel_projection_histogram_top: row and column projection histogram
// Classifies raster pixels, emits a count per row at row end and keeps a
// count per column that a read word returns and clears.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                word
//  in       input      in_valid_i / in_stall_o  pph_pkg::in_word_t
//  out      output     out_valid_o / out_stall_i pph_pkg::out_word_t
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One word per cycle when not stalled by the column clear or a stalled output;
// a word is held in the input register, its result in the output register.
// The column memory read is issued on accept and resolved in the input stage.
// After reset a clearing sweep zeroes all 1024 words of the column memory;
// in_stall_o stays high meanwhile. Configuration writes are taken at once.
// A stalled output holds only words that make a result; others still retire.
// ----------------------------------------------------------------------------
module pixel_projection_histogram_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pph_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pph_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  logic [pph_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pph_pkg::CfgW-1:0]      cfg_wdata_i
);

  localparam int unsigned WCapRaw = (MAX_WIDTH < pph_pkg::Span) ? MAX_WIDTH : pph_pkg::Span;
  localparam int unsigned HCapRaw = (MAX_HEIGHT < pph_pkg::Span) ? MAX_HEIGHT : pph_pkg::Span;
  localparam int unsigned WCap    = (WCapRaw == 0) ? 1 : WCapRaw;
  localparam int unsigned HCap    = (HCapRaw == 0) ? 1 : HCapRaw;

  logic [pph_pkg::CfgW-1:0] width_q, height_q;
  logic                     nonzero_q;

  logic                     v1_q;
  pph_pkg::in_word_t        item1_q;
  logic                     out_valid_q;
  pph_pkg::out_word_t       out_word_q;

  logic                     accept, adv1, produces, out_free, counted, is_read;
  logic                     step, store_done;
  logic [pph_pkg::CntW-1:0] rd_data;
  logic [pph_pkg::PosW-1:0] col, col_next, row;
  logic [pph_pkg::CntW-1:0] row_tally;
  logic                     row_end, last_row;
  pph_pkg::store_req_t      req;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 11'd640;
      height_q  <= 11'd480;
      nonzero_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pph_pkg::CFG_FRAME_WIDTH:   width_q   <= cfg_wdata_i;
        pph_pkg::CFG_FRAME_HEIGHT:  height_q  <= cfg_wdata_i;
        pph_pkg::CFG_COUNT_NONZERO: nonzero_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Classify the word held in the input register
  assign is_read  = item1_q.action == pph_pkg::ACT_READ;
  assign counted  = nonzero_q == ((item1_q.blue | item1_q.green | item1_q.red) != 8'd0);
  assign produces = is_read || row_end;
  assign out_free = !out_valid_q || !out_stall_i;
  assign adv1     = v1_q && (!produces || out_free);
  assign step     = adv1 && !is_read;
  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = !store_done || (v1_q && !adv1);

  pph_raster #(
    .WidthCap  (WCap),
    .HeightCap (HCap)
  ) u_raster (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .step_i         (step),
    .counted_i      (counted),
    .col_o          (col),
    .col_next_o     (col_next),
    .row_end_o      (row_end),
    .row_o          (row),
    .tally_o        (row_tally),
    .last_row_o     (last_row)
  );

  // Read on accept, write back as the held word retires
  always_comb begin
    req.rd_en   = accept;
    req.rd_addr = (in_word_i.action == pph_pkg::ACT_READ) ? in_word_i.column_select : col_next;
    req.wr_en   = adv1 && (is_read || counted);
    req.wr_addr = is_read ? item1_q.column_select : col;
    req.wr_data = is_read ? '0 : pph_pkg::bump(rd_data);
  end

  pph_col_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .init_done_o (store_done),
    .rd_data_o   (rd_data)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (accept) begin
      v1_q <= 1'b1;
    end else if (adv1) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item1_q <= in_word_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv1 && produces) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && produces) begin
      if (is_read) begin
        out_word_q.result_kind <= pph_pkg::KIND_COLUMN;
        out_word_q.position    <= item1_q.column_select;
        out_word_q.tally       <= rd_data;
        out_word_q.frame_done  <= 1'b0;
      end else begin
        out_word_q.result_kind <= pph_pkg::KIND_ROW;
        out_word_q.position    <= row;
        out_word_q.tally       <= row_tally;
        out_word_q.frame_done  <= last_row;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef ASSERT_OFF
  // No word enters while the column memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> store_done)
    else $error("word accepted during column clear");

  // A held word that cannot retire stays put
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv1) |=> (v1_q && $stable(item1_q)))
    else $error("input stage lost a held word");

  // Column results never close a frame
  a_read_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.result_kind == pph_pkg::KIND_COLUMN)) |-> !out_word_o.frame_done)
    else $error("column result flagged frame end");

  // Counts saturate at the cap
  a_tally_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.tally <= pph_pkg::CountCap))
    else $error("tally above cap");
`endif

endmodule

FILE: hdl/pph_col_store.sv
// ----------------------------------------------------------------------------
// pph_col_store: column count memory
// One count per column in a single-port-write, single-port-read memory with
// registered read data, write-to-read forwarding and a clearing pass after
// reset.
// ----------------------------------------------------------------------------
module pph_col_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pph_pkg::store_req_t               req_i,
  output logic                              init_done_o,
  output logic [pph_pkg::CntW-1:0]          rd_data_o
);

  logic [pph_pkg::CntW-1:0] mem [pph_pkg::Span];
  logic [pph_pkg::CntW-1:0] rdata_q;
  logic [pph_pkg::CntW-1:0] fwd_data_q;
  logic                     fwd_hit_q;
  logic [pph_pkg::PosW:0]   clr_q;
  logic [pph_pkg::PosW:0]   clr_d;
  logic                     done;
  logic                     fwd_hit_d;

  assign done      = clr_q[pph_pkg::PosW];
  assign clr_d     = done ? clr_q : clr_q + 11'd1;
  assign fwd_hit_d = req_i.rd_en && req_i.wr_en && (req_i.rd_addr == req_i.wr_addr);

  // Advance the clearing sweep and track forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      fwd_hit_q <= 1'b0;
    end else begin
      clr_q <= clr_d;
      if (req_i.rd_en) begin
        fwd_hit_q <= fwd_hit_d;
      end
    end
  end

  // Write: zero during the sweep, then the requested word
  always_ff @(posedge clk_i) begin
    if (!done) begin
      mem[clr_q[pph_pkg::PosW-1:0]] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Read with registered data; hold a write that lands on the same address
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q    <= mem[req_i.rd_addr];
      fwd_data_q <= req_i.wr_data;
    end
  end

  assign init_done_o = done;
  assign rd_data_o   = fwd_hit_q ? fwd_data_q : rdata_q;

endmodule

FILE: hdl/pph_raster.sv
// ----------------------------------------------------------------------------
// pph_raster: raster position and row count
// Tracks column and row against the effective frame size, keeps the running
// row count and forms the row result fields.
// ----------------------------------------------------------------------------
module pph_raster #(
  parameter int unsigned WidthCap  = 1024,
  parameter int unsigned HeightCap = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pph_pkg::CfgW-1:0]    frame_width_i,
  input  logic [pph_pkg::CfgW-1:0]    frame_height_i,
  input  logic                        step_i,
  input  logic                        counted_i,
  output logic [pph_pkg::PosW-1:0]    col_o,
  output logic [pph_pkg::PosW-1:0]    col_next_o,
  output logic                        row_end_o,
  output logic [pph_pkg::PosW-1:0]    row_o,
  output logic [pph_pkg::CntW-1:0]    tally_o,
  output logic                        last_row_o
);

  localparam logic [pph_pkg::CfgW-1:0] WCap = pph_pkg::CfgW'(WidthCap);
  localparam logic [pph_pkg::CfgW-1:0] HCap = pph_pkg::CfgW'(HeightCap);

  logic [pph_pkg::PosW-1:0] col_q, col_d;
  logic [pph_pkg::PosW-1:0] row_q, row_d;
  logic [pph_pkg::CntW-1:0] tally_q, tally_d;
  logic [pph_pkg::CntW-1:0] w_eff, h_eff;
  logic [pph_pkg::CntW-1:0] tally_new;
  logic [pph_pkg::CntW-1:0] col_inc, row_inc;

  // Clamp the frame size into its usable range
  always_comb begin
    if (frame_width_i == '0) begin
      w_eff = 11'd1;
    end else if (frame_width_i > WCap) begin
      w_eff = WCap;
    end else begin
      w_eff = frame_width_i;
    end
    if (frame_height_i == '0) begin
      h_eff = 11'd1;
    end else if (frame_height_i > HCap) begin
      h_eff = HCap;
    end else begin
      h_eff = frame_height_i;
    end
  end

  assign col_inc   = {1'b0, col_q} + 11'd1;
  assign row_inc   = {1'b0, row_q} + 11'd1;
  assign row_end_o = !(col_inc < w_eff);
  assign last_row_o = row_inc >= h_eff;
  assign tally_new = counted_i ? pph_pkg::bump(tally_q) : tally_q;

  // Advance the raster on each pixel
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    tally_d = tally_q;
    if (step_i) begin
      if (row_end_o) begin
        col_d   = '0;
        tally_d = '0;
        row_d   = last_row_o ? '0 : row_inc[pph_pkg::PosW-1:0];
      end else begin
        col_d   = col_inc[pph_pkg::PosW-1:0];
        tally_d = tally_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      tally_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      tally_q <= tally_d;
    end
  end

  assign col_o      = col_q;
  assign col_next_o = col_d;
  assign row_o      = row_q;
  assign tally_o    = tally_new;

endmodule

FILE: tb/pixel_projection_histogram_top_test.sv
// ----------------------------------------------------------------------------
// pixel_projection_histogram_top_test: projection histogram testbench
// Streams pixel and read words through the block under random idling on both
// channels, predicts every row and column count in a scoreboard that keeps its
// own raster position and column store, and compares each result word field
// by field. A directed opening covers the reset setup, both polarities, frame
// sizes out of range, size changes in the middle of a row or frame, a tall
// one-column frame, a wide row, and reads outside the frame. Random phases
// follow.
// ----------------------------------------------------------------------------
module pixel_projection_histogram_top_test;
  import pph_pkg::*;

  localparam int unsigned WidthLimit  = 1024;
  localparam int unsigned HeightLimit = 1024;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned PhaseWords  = 56;

  // Predicted projection state and the queue of result words still owed
  class projection_ledger;
    int unsigned     width_cap;
    int unsigned     height_cap;
    logic [CfgW-1:0] width_reg;
    logic [CfgW-1:0] height_reg;
    logic            count_set;
    logic [CntW-1:0] column_tally [Span];
    logic [CntW-1:0] row_tally;
    logic [PosW-1:0] col_pos;
    logic [PosW-1:0] row_pos;
    out_word_t       pending_words [$];
    int              mismatches;

    function new(int unsigned wlim, int unsigned hlim);
      width_cap  = wlim;
      height_cap = hlim;
      width_reg  = 11'd640;
      height_reg = 11'd480;
      count_set  = 1'b1;
      foreach (column_tally[i]) column_tally[i] = '0;
      row_tally  = '0;
      col_pos    = '0;
      row_pos    = '0;
      mismatches = 0;
    endfunction

    function void set_setup(logic [CfgW-1:0] w, logic [CfgW-1:0] h, logic p);
      width_reg  = w;
      height_reg = h;
      count_set  = p;
    endfunction

    // Map a size register onto the range the block can hold
    function int unsigned frame_size(logic [CfgW-1:0] v, int unsigned lim);
      int unsigned top;
      top = (lim < Span) ? lim : Span;
      if (top == 0) top = 1;
      if (v == '0) return 1;
      return (int'(v) > top) ? top : int'(v);
    endfunction

    function void note_accepted(in_word_t w);
      out_word_t   res;
      logic        hit;
      logic        last_row;
      int unsigned wid;
      int unsigned hgt;
      // Read word: return the column count and clear it
      if (w.action == ACT_READ) begin
        res.result_kind = KIND_COLUMN;
        res.position    = w.column_select;
        res.tally       = column_tally[w.column_select];
        res.frame_done  = 1'b0;
        column_tally[w.column_select] = '0;
        pending_words.push_back(res);
        return;
      end
      // Pixel word: classify, count, advance the raster position
      hit = (|{w.blue, w.green, w.red}) ? count_set : !count_set;
      wid = frame_size(width_reg, width_cap);
      hgt = frame_size(height_reg, height_cap);
      if (hit) begin
        if (row_tally < CountCap) row_tally = row_tally + 1'b1;
        if (column_tally[col_pos] < CountCap) begin
          column_tally[col_pos] = column_tally[col_pos] + 1'b1;
        end
      end
      if (int'(col_pos) + 1 < wid) begin
        col_pos = col_pos + 1'b1;
      end else begin
        last_row        = (int'(row_pos) + 1 >= hgt);
        res.result_kind = KIND_ROW;
        res.position    = row_pos;
        res.tally       = row_tally;
        res.frame_done  = last_row;
        pending_words.push_back(res);
        row_tally = '0;
        col_pos   = '0;
        row_pos   = last_row ? '0 : row_pos + 1'b1;
      end
    endfunction

    function void note_failure(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: MISMATCH %s", $realtime, what);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_words.size() == 0) begin
        note_failure($sformatf("unexpected word kind=%0d pos=%0d tally=%0d done=%0d",
                               got.result_kind, got.position, got.tally, got.frame_done));
        return;
      end
      want = pending_words.pop_front();
      if (got.result_kind !== want.result_kind || got.position !== want.position ||
          got.tally !== want.tally || got.frame_done !== want.frame_done) begin
        note_failure($sformatf(
          "expected kind=%0d pos=%0d tally=%0d done=%0d, got kind=%0d pos=%0d tally=%0d done=%0d",
          want.result_kind, want.position, want.tally, want.frame_done,
          got.result_kind, got.position, got.tally, got.frame_done));
      end
    endfunction
  endclass

  logic            clk_i      = 1'b0;
  logic            rst_ni     = 1'b0;
  logic            in_valid   = 1'b0;
  logic            in_stall_o;
  in_word_t        in_word    = '0;
  logic            out_valid_o;
  logic            out_stall  = 1'b0;
  out_word_t       out_word_o;
  logic            cfg_we     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_wdata  = '0;
  bit              calm       = 1'b0;

  projection_ledger tallies;

  pixel_projection_histogram_top #(
    .MAX_WIDTH  (WidthLimit),
    .MAX_HEIGHT (HeightLimit)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Pick an idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t make_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    in_word_t w;
    w.action        = ACT_PIXEL;
    w.blue          = b;
    w.green         = g;
    w.red           = r;
    w.column_select = PosW'($urandom_range(0, Span - 1));
    return w;
  endfunction

  function automatic in_word_t make_read(logic [PosW-1:0] col);
    in_word_t w;
    w.action        = ACT_READ;
    w.blue          = 8'($urandom_range(0, 255));
    w.green         = 8'($urandom_range(0, 255));
    w.red           = 8'($urandom_range(0, 255));
    w.column_select = col;
    return w;
  endfunction

  // Random pixel: black, one lone bit in one channel, or full noise
  function automatic in_word_t rand_pixel();
    logic [7:0] bit_val;
    bit_val = 8'd1 << $urandom_range(0, 7);
    case ($urandom_range(0, 4))
      0, 1: return make_pixel(8'd0, 8'd0, 8'd0);
      2: begin
        case ($urandom_range(0, 2))
          0: return make_pixel(bit_val, 8'd0, 8'd0);
          1: return make_pixel(8'd0, bit_val, 8'd0);
          default: return make_pixel(8'd0, 8'd0, bit_val);
        endcase
      end
      default: return make_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
    endcase
  endfunction

  // Read target: mostly low columns, some anywhere, some at the ends
  function automatic logic [PosW-1:0] rand_column();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return PosW'($urandom_range(0, 15));
    if (r < 8) return PosW'($urandom_range(0, Span - 1));
    return (r == 8) ? '0 : PosW'(Span - 1);
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tallies.pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive edges; junk in the unused bits
  task automatic load_setup(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h,
                            input logic p);
    logic [CfgW-2:0] junk;
    junk = 10'($urandom_range(0, 1023));
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_idx   <= CFG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk_i);
    cfg_idx   <= CFG_COUNT_NONZERO;
    cfg_wdata <= {junk, p};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tallies.set_setup(w, h, p);
  endtask

  // Random frame size: mostly tiny, a few zero, at the cap or beyond it
  function automatic logic [CfgW-1:0] rand_size(int unsigned small_top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CfgW'($urandom_range(1, small_top));
    if (r < 80) return CfgW'($urandom_range(small_top + 1, 40));
    if (r < 88) return '0;
    if (r < 93) return 11'd1024;
    return CfgW'($urandom_range(1025, 2047));
  endfunction

  // Watch both channels and feed the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) tallies.note_accepted(in_word);
      if (out_valid_o && !out_stall) tallies.check_result(out_word_o);
    end
  end

  // Stall the output in random bursts
  always @(posedge clk_i) begin : sink_pattern
    int sink_wait;
    int g;
    if (sink_wait > 0) begin
      sink_wait = sink_wait - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      sink_wait = $urandom_range(0, 8);
    end else begin
      g = pick_gap();
      if (g > 0) begin
        out_stall <= 1'b1;
        sink_wait = g - 1;
      end
    end
  end

  // Stop a hung run
  initial begin
    #(8 * 3000000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n;
    tallies = new(WidthLimit, HeightLimit);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setup: a few pixels mid-row, then reads inside and outside the frame
    send_word(make_pixel(8'h00, 8'h00, 8'h00));
    send_word(make_pixel(8'hff, 8'hff, 8'hff));
    send_word(make_pixel(8'h01, 8'h00, 8'h00));
    send_word(make_pixel(8'h00, 8'h80, 8'h00));
    send_word(make_pixel(8'h00, 8'h00, 8'h55));
    send_word(make_read(10'd1));
    send_word(make_read(10'd0));
    send_word(make_read(10'd1023));

    // Shrink the width past the current column; count black pixels
    wait_idle();
    load_setup(11'd3, 11'd2, 1'b0);
    send_word(make_pixel(8'h00, 8'h00, 8'h00));
    send_word(make_pixel(8'hff, 8'hff, 8'hff));
    send_word(make_pixel(8'h00, 8'h00, 8'h00));
    send_word(make_pixel(8'h00, 8'h01, 8'h00));
    send_word(make_read(10'd5));
    send_word(make_read(10'd1));

    // Shrink the height past the current row
    wait_idle();
    load_setup(11'd3, 11'd4, 1'b1);
    repeat (6) send_word(rand_pixel());
    wait_idle();
    load_setup(11'd3, 11'd1, 1'b1);
    repeat (3) send_word(rand_pixel());

    // Zero sizes act as one; oversized ones clamp to the cap
    wait_idle();
    load_setup(11'd0, 11'd0, 1'b1);
    repeat (2) send_word(rand_pixel());
    wait_idle();
    load_setup(11'd2047, 11'd1025, 1'b0);
    repeat (3) send_word(rand_pixel());
    send_word(make_read(10'd2));

    // One column counted down a tall frame, a row end on every pixel
    wait_idle();
    load_setup(11'd1, 11'd1024, 1'b1);
    repeat (40) send_word(make_pixel(8'($urandom_range(1, 255)), 8'h00, 8'h00));
    send_word(make_read(10'd0));
    send_word(make_read(10'd3));

    // Start of a full-width row of counted pixels
    wait_idle();
    load_setup(11'd1024, 11'd1024, 1'b0);
    repeat (20) send_word(make_pixel(8'h00, 8'h00, 8'h00));
    send_word(make_read(10'd1023));
    send_word(make_read(10'd0));

    // Random phases: raster streams with scattered reads
    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      calm = (ph % 4 == 3);
      load_setup(rand_size(8), rand_size(6), $urandom_range(0, 1));
      n = 0;
      while (n < PhaseWords) begin
        if ($urandom_range(0, 99) < 15) begin
          send_word(make_read(rand_column()));
        end else begin
          send_word(rand_pixel());
        end
        n++;
      end
    end
    calm = 1'b0;

    wait_idle();
    if (tallies.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pph_pkg.sv
hdl/pph_col_store.sv
hdl/pph_raster.sv
hdl/pixel_projection_histogram_top.sv
tb/pixel_projection_histogram_top_test.sv
